@@ hdl/spso_pkg.sv @@
package spso_pkg;

  localparam int TOPPLE_AT = 4;

  typedef enum logic [1:0] {
    F_CLEAR = 2'd0,
    F_ADD   = 2'd1,
    F_READ  = 2'd2,
    F_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    NB_UP    = 2'd0,
    NB_DOWN  = 2'd1,
    NB_LEFT  = 2'd2,
    NB_RIGHT = 2'd3
  } nb_dir_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH_IN,
    OP_SWEEP,
    OP_CORE,
    OP_RD_IN,
    OP_ADD_WR,
    OP_Q_RD,
    OP_CUR_RD,
    OP_TOP_CHK,
    OP_NB_RD,
    OP_NB_WR,
    OP_RD_LATCH,
    OP_LOAD_OUT
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWEEP,
    ST_CORE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_Q_RD,
    ST_CUR_RD,
    ST_TOP_CHK,
    ST_NB_RD,
    ST_NB_WR,
    ST_RD_CELL,
    ST_RD_WAIT,
    ST_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic        mark;
    logic [31:0] od;
    logic [31:0] h;
  } cell_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [5:0]  cell_row;
    logic [5:0]  cell_col;
    logic [15:0] grain_count;
    logic [1:0]  core_a;
    logic [1:0]  core_b;
    logic [1:0]  core_d;
    logic [1:0]  core_c;
  } in_word_t;

  typedef struct packed {
    logic [31:0] cell_height;
    logic [31:0] cell_topples;
    logic        border_error;
    logic        op_done;
  } out_word_t;

  typedef struct packed {
    func_t func;
    logic  in_grid;
    logic  err;
    logic  sweep_last;
    logic  core_last;
    logic  q_empty;
    logic  tzero;
    logic  border;
    logic  nb_last;
    logic  out_free;
  } dp_status_t;

endpackage

@@ hdl/spso_if.sv @@
interface spso_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [5:0]  cell_row;
  logic [5:0]  cell_col;
  logic [15:0] grain_count;
  logic [1:0]  core_a;
  logic [1:0]  core_b;
  logic [1:0]  core_d;
  logic [1:0]  core_c;

  modport source (output valid, func, cell_row, cell_col, grain_count,
                  core_a, core_b, core_d, core_c, input ready);
  modport sink (input valid, func, cell_row, cell_col, grain_count,
                core_a, core_b, core_d, core_c, output ready);
endinterface

interface spso_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] cell_height;
  logic [31:0] cell_topples;
  logic        border_error;
  logic        op_done;

  modport source (output valid, cell_height, cell_topples, border_error, op_done,
                  input ready);
  modport sink (input valid, cell_height, cell_topples, border_error, op_done,
                output ready);
endinterface

@@ hdl/spso_ram.sv @@
module spso_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/spso_dp.sv @@
module spso_dp #(
  parameter int GRID_SIDE = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  spso_pkg::dp_op_t      op,
  output spso_pkg::dp_status_t  st,
  input  spso_pkg::in_word_t    in_word,
  input  logic                  out_ready,
  output logic                  out_valid,
  output spso_pkg::out_word_t   out_word
);
  import spso_pkg::*;

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int AW = $clog2(CELLS);
  localparam int RW = $clog2(GRID_SIDE);
  localparam int QW = 2 * RW;
  localparam int MID = GRID_SIDE / 2;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                              input logic [RW-1:0] c);
    return AW'(int'(r) * GRID_SIDE + int'(c));
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (int'(p) == CELLS - 1) ? '0 : AW'(int'(p) + 1);
  endfunction

  logic [AW-1:0] sweep_cnt_r, head_r, tail_r;
  logic [1:0]    core_idx_r;
  nb_dir_t       nb_idx_r;
  logic          err_r, out_valid_r;

  func_t         func_r;
  logic [RW-1:0] row_r, col_r, cur_row_r, cur_col_r;
  logic [15:0]   amt_r;
  logic [1:0]    core_r [4];
  logic [29:0]   t_r;
  logic [31:0]   res_h_r, res_od_r;
  logic          done_r;
  out_word_t     out_r;

  logic          g_we, g_re, q_we, q_re;
  logic [AW-1:0] g_waddr, g_raddr;
  cell_t         g_wdata, g_rdata, g_rd_cell;
  logic [$bits(cell_t)-1:0] g_rdata_raw;
  logic [QW-1:0] q_wdata, q_rdata;

  logic [RW-1:0] nb_row, nb_col;
  logic [AW-1:0] in_addr, cur_addr, nb_addr;
  logic [31:0]   add_src, hs;
  logic          push, tzero, border, in_grid;

  assign g_rdata = cell_t'(g_rdata_raw);
  assign g_rd_cell = g_rdata;

  assign in_grid = (int'(in_word.cell_row) < GRID_SIDE) &&
                   (int'(in_word.cell_col) < GRID_SIDE);

  always_comb begin
    nb_row = cur_row_r;
    nb_col = cur_col_r;
    case (nb_idx_r)
      NB_UP:    nb_row = cur_row_r - 1'b1;
      NB_DOWN:  nb_row = cur_row_r + 1'b1;
      NB_LEFT:  nb_col = cur_col_r - 1'b1;
      default:  nb_col = cur_col_r + 1'b1;
    endcase
  end

  assign in_addr  = cell_addr(row_r, col_r);
  assign cur_addr = cell_addr(cur_row_r, cur_col_r);
  assign nb_addr  = cell_addr(nb_row, nb_col);

  assign add_src = (op == OP_NB_WR) ? 32'(t_r) : 32'(amt_r);
  assign hs      = sat_add(g_rd_cell.h, add_src);
  assign push    = ((op == OP_ADD_WR) || (op == OP_NB_WR)) &&
                   (hs >= 32'(TOPPLE_AT)) && !g_rd_cell.mark;
  assign tzero   = (g_rd_cell.h[31:2] == '0);
  assign border  = (cur_row_r == '0) || (int'(cur_row_r) >= GRID_SIDE - 1) ||
                   (cur_col_r == '0) || (int'(cur_col_r) >= GRID_SIDE - 1);

  always_comb begin
    g_we    = 1'b0;
    g_re    = 1'b0;
    g_waddr = in_addr;
    g_raddr = in_addr;
    g_wdata = g_rd_cell;
    q_we    = push;
    q_re    = 1'b0;
    q_wdata = {row_r, col_r};
    case (op)
      OP_SWEEP: begin
        g_we    = 1'b1;
        g_waddr = sweep_cnt_r;
        g_wdata = '0;
      end
      OP_CORE: begin
        g_we    = 1'b1;
        g_waddr = cell_addr(RW'(MID + int'(core_idx_r[1])),
                            RW'(MID + int'(core_idx_r[0])));
        g_wdata = '0;
        g_wdata.h = 32'(core_r[core_idx_r]);
      end
      OP_RD_IN: begin
        g_re = 1'b1;
      end
      OP_ADD_WR: begin
        g_we      = 1'b1;
        g_wdata.h = hs;
        g_wdata.mark = g_rd_cell.mark | push;
      end
      OP_Q_RD: begin
        q_re = 1'b1;
      end
      OP_CUR_RD: begin
        g_re    = 1'b1;
        g_raddr = cell_addr(q_rdata[QW-1:RW], q_rdata[RW-1:0]);
      end
      OP_TOP_CHK: begin
        g_we         = 1'b1;
        g_waddr      = cur_addr;
        g_wdata.mark = 1'b0;
        if (!tzero && !border) begin
          g_wdata.h  = {30'd0, g_rd_cell.h[1:0]};
          g_wdata.od = sat_add(g_rd_cell.od, {2'd0, g_rd_cell.h[31:2]});
        end
      end
      OP_NB_RD: begin
        g_re    = 1'b1;
        g_raddr = nb_addr;
      end
      OP_NB_WR: begin
        g_we         = 1'b1;
        g_waddr      = nb_addr;
        g_wdata.h    = hs;
        g_wdata.mark = g_rd_cell.mark | push;
        q_wdata      = {nb_row, nb_col};
      end
      default: ;
    endcase
  end

  spso_ram #(.WIDTH($bits(cell_t)), .DEPTH(CELLS)) u_grid (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .re    (g_re),
    .raddr (g_raddr),
    .rdata (g_rdata_raw)
  );

  spso_ram #(.WIDTH(QW), .DEPTH(CELLS)) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail_r),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (head_r),
    .rdata (q_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_cnt_r <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      core_idx_r  <= '0;
      nb_idx_r    <= NB_UP;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (op == OP_LOAD_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (push) begin
        tail_r <= ptr_inc(tail_r);
      end
      case (op)
        OP_SWEEP: begin
          sweep_cnt_r <= ptr_inc(sweep_cnt_r);
        end
        OP_CORE: begin
          core_idx_r <= core_idx_r + 1'b1;
          err_r      <= 1'b0;
        end
        OP_RD_IN: begin
          head_r <= '0;
          tail_r <= '0;
        end
        OP_Q_RD: begin
          head_r <= ptr_inc(head_r);
        end
        OP_TOP_CHK: begin
          if (!tzero && border) begin
            err_r <= 1'b1;
          end
        end
        OP_NB_WR: begin
          nb_idx_r <= nb_dir_t'(2'(nb_idx_r + 2'd1));
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LATCH_IN: begin
        func_r    <= func_t'(in_word.func);
        row_r     <= RW'(in_word.cell_row);
        col_r     <= RW'(in_word.cell_col);
        amt_r     <= in_word.grain_count;
        core_r[0] <= in_word.core_a;
        core_r[1] <= in_word.core_b;
        core_r[2] <= in_word.core_d;
        core_r[3] <= in_word.core_c;
        res_h_r   <= '0;
        res_od_r  <= '0;
        done_r    <= (func_t'(in_word.func) != F_NONE);
      end
      OP_CUR_RD: begin
        cur_row_r <= q_rdata[QW-1:RW];
        cur_col_r <= q_rdata[RW-1:0];
      end
      OP_TOP_CHK: begin
        t_r <= g_rd_cell.h[31:2];
      end
      OP_RD_LATCH: begin
        res_h_r  <= g_rd_cell.h;
        res_od_r <= g_rd_cell.od;
      end
      OP_LOAD_OUT: begin
        out_r.cell_height  <= (func_r == F_READ) ? res_h_r : '0;
        out_r.cell_topples <= (func_r == F_READ) ? res_od_r : '0;
        out_r.border_error <= err_r;
        out_r.op_done      <= done_r;
      end
      default: ;
    endcase
  end

  assign st.func       = func_t'(in_word.func);
  assign st.in_grid    = in_grid;
  assign st.err        = err_r;
  assign st.sweep_last = (int'(sweep_cnt_r) == CELLS - 1);
  assign st.core_last  = (core_idx_r == '1);
  assign st.q_empty    = (head_r == tail_r);
  assign st.tzero      = tzero;
  assign st.border     = border;
  assign st.nb_last    = (nb_idx_r == NB_RIGHT);
  assign st.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

@@ hdl/spso_ctrl.sv @@
module spso_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  spso_pkg::dp_status_t st,
  output spso_pkg::dp_op_t     op
);
  import spso_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        op = OP_SWEEP;
        if (st.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op = OP_LATCH_IN;
          unique case (st.func)
            F_CLEAR: state_nxt = ST_SWEEP;
            F_ADD:   state_nxt = (st.in_grid && !st.err) ? ST_ADD_RD : ST_RESP;
            F_READ:  state_nxt = st.in_grid ? ST_RD_CELL : ST_RESP;
            default: state_nxt = ST_RESP;
          endcase
        end
      end
      ST_SWEEP: begin
        op = OP_SWEEP;
        if (st.sweep_last) state_nxt = ST_CORE;
      end
      ST_CORE: begin
        op = OP_CORE;
        if (st.core_last) state_nxt = ST_RESP;
      end
      ST_ADD_RD: begin
        op        = OP_RD_IN;
        state_nxt = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        op        = OP_ADD_WR;
        state_nxt = ST_Q_RD;
      end
      ST_Q_RD: begin
        if (st.q_empty) begin
          state_nxt = ST_RESP;
        end else begin
          op        = OP_Q_RD;
          state_nxt = ST_CUR_RD;
        end
      end
      ST_CUR_RD: begin
        op        = OP_CUR_RD;
        state_nxt = ST_TOP_CHK;
      end
      ST_TOP_CHK: begin
        op = OP_TOP_CHK;
        if (st.tzero) begin
          state_nxt = ST_Q_RD;
        end else if (st.border) begin
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_NB_RD;
        end
      end
      ST_NB_RD: begin
        op        = OP_NB_RD;
        state_nxt = ST_NB_WR;
      end
      ST_NB_WR: begin
        op        = OP_NB_WR;
        state_nxt = st.nb_last ? ST_Q_RD : ST_NB_RD;
      end
      ST_RD_CELL: begin
        op        = OP_RD_IN;
        state_nxt = ST_RD_WAIT;
      end
      ST_RD_WAIT: begin
        op        = OP_RD_LATCH;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (st.out_free) begin
          op        = OP_LOAD_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ hdl/sandpile_stabilizer_with_odometer_unit.sv @@
// Abelian sandpile on a GRID_SIDE x GRID_SIDE grid, one item at a time, one result word
// per item. After reset the block sweeps the grid clear before it takes the first word.
// A clear sweeps the grid memory one cell per cycle and then writes the four core cells.
// An add's length follows the size of the avalanche, since every queue entry and every
// neighbor update is a registered read followed by a write of the grid memory. The
// result word sits in an output register, so the next word is taken while it waits.
module sandpile_stabilizer_with_odometer_unit #(
  parameter int GRID_SIDE = 64
) (
  input logic       clk,
  input logic       rst_n,
  spso_in_if.sink   in_w,
  spso_out_if.source out_w
);
  import spso_pkg::*;

  dp_status_t st;
  dp_op_t     op;
  in_word_t   in_word;
  out_word_t  out_word;
  logic       in_ready;
  logic       out_valid;

  assign in_word.func        = in_w.func;
  assign in_word.cell_row    = in_w.cell_row;
  assign in_word.cell_col    = in_w.cell_col;
  assign in_word.grain_count = in_w.grain_count;
  assign in_word.core_a      = in_w.core_a;
  assign in_word.core_b      = in_w.core_b;
  assign in_word.core_d      = in_w.core_d;
  assign in_word.core_c      = in_w.core_c;
  assign in_w.ready          = in_ready;

  spso_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_w.valid),
    .in_ready (in_ready),
    .st       (st),
    .op       (op)
  );

  spso_dp #(.GRID_SIDE(GRID_SIDE)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .st        (st),
    .in_word   (in_word),
    .out_ready (out_w.ready),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  assign out_w.valid        = out_valid;
  assign out_w.cell_height  = out_word.cell_height;
  assign out_w.cell_topples = out_word.cell_topples;
  assign out_w.border_error = out_word.border_error;
  assign out_w.op_done      = out_word.op_done;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_w.valid && in_w.ready) |=> !in_w.ready)
    else $error("input taken again right after a word was accepted");

  a_undone_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_w.valid && !out_w.op_done) |-> (out_w.cell_height == 32'd0 &&
                                         out_w.cell_topples == 32'd0))
    else $error("unused function code returned cell data");

  a_sweep_after_reset: assert property (@(posedge clk)
    !rst_n |=> (!in_w.ready && !out_w.valid))
    else $error("block ready before the clearing sweep");

endmodule
